@@ hw/rtl/bqd_pkg.sv @@
// Shared types and constants for the biquad filter with coefficient smoothing.
`default_nettype none

package bqd_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned STATE_W    = 32;
  localparam int unsigned DIFF_W     = COEF_W + 1;
  localparam int unsigned PROD_W     = DIFF_W + COEF_W;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned COEF_FRAC  = 28;
  localparam int unsigned RND_W      = PROD_W - COEF_FRAC;
  localparam int unsigned RAMP_NUM   = 3277;
  localparam int unsigned RAMP_SHIFT = 16;
  localparam int unsigned NUM_COEF   = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COEF_IDX_W = 3;

  localparam logic [COEF_W-1:0] COEF_ONE = 32'h1000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_B0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_B1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_B2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_A2 = 3'd5;

  localparam logic [COEF_IDX_W-1:0] COEF_B0 = 3'd0;
  localparam logic [COEF_IDX_W-1:0] COEF_B1 = 3'd1;
  localparam logic [COEF_IDX_W-1:0] COEF_B2 = 3'd2;
  localparam logic [COEF_IDX_W-1:0] COEF_A1 = 3'd3;
  localparam logic [COEF_IDX_W-1:0] COEF_A2 = 3'd4;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_RAMP   = 1'b1;

  typedef enum logic [1:0] {
    BSEL_D0,
    BSEL_D1,
    BSEL_W,
    BSEL_RAMP
  } b_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB,
    ACC_ADD,
    ACC_CLR
  } acc_op_e;

  typedef struct packed {
    logic                  x_load;
    logic                  mul_en;
    logic                  a_diff;
    b_sel_e                b_sel;
    logic [COEF_IDX_W-1:0] coef_idx;
    acc_op_e               acc_op;
    logic                  w_load;
    logic                  diff_load;
    logic                  coef_wr;
    logic                  out_load;
    logic                  out_pass;
  } cmd_t;

  typedef struct packed {
    logic enable;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/bqd_dp.sv @@
// Datapath: registers, shared multiplier, accumulator and saturation.
`default_nettype none

module bqd_dp import bqd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [COEF_W-1:0]     cfg_data_i,
  input  wire logic [SAMPLE_W-1:0]   in_sample_i,
  output logic      [SAMPLE_W-1:0]   out_sample_o
);

  function automatic logic [STATE_W-1:0] sat_state(logic signed [ACC_W-1:0] v);
    if (v > 40'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -40'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[STATE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_sample(logic signed [ACC_W-1:0] v);
    if (v > 40'sd8388607) begin
      return 24'h7f_ffff;
    end else if (v < -40'sd8388608) begin
      return 24'h80_0000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  logic                      enable_q;
  logic [COEF_W-1:0]         tgt_q [NUM_COEF];
  logic [COEF_W-1:0]         cur_q [NUM_COEF];
  logic [STATE_W-1:0]        d0_q, d1_q;
  logic [SAMPLE_W-1:0]       x_q;
  logic [STATE_W-1:0]        w_q;
  logic signed [DIFF_W-1:0]  diff_q, diff_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [SAMPLE_W-1:0]       out_q;

  logic [COEF_W-1:0]         cur_sel, tgt_sel;
  logic signed [DIFF_W-1:0]  a_op;
  logic signed [COEF_W-1:0]  b_op;
  logic signed [PROD_W-1:0]  rnd_sum;
  logic signed [ACC_W-1:0]   rnd;
  logic [COEF_W+1:0]         ramp_sum;
  logic [COEF_W-1:0]         ramp_new;

  assign cur_sel = cur_q[cmd_i.coef_idx];
  assign tgt_sel = tgt_q[cmd_i.coef_idx];
  assign diff_d  = $signed({tgt_sel[COEF_W-1], tgt_sel}) - $signed({cur_sel[COEF_W-1], cur_sel});
  assign a_op    = cmd_i.a_diff ? diff_q : $signed({cur_sel[COEF_W-1], cur_sel});

  always_comb begin
    case (cmd_i.b_sel)
      BSEL_D0:   b_op = $signed(d0_q);
      BSEL_D1:   b_op = $signed(d1_q);
      BSEL_W:    b_op = $signed(w_q);
      BSEL_RAMP: b_op = $signed(COEF_W'(RAMP_NUM));
      default:   b_op = $signed(d0_q);
    endcase
  end

  assign prod_d  = a_op * b_op;
  assign rnd_sum = prod_q + $signed(PROD_W'(1) << (COEF_FRAC - 1));
  assign rnd     = $signed({{(ACC_W-RND_W){rnd_sum[PROD_W-1]}}, rnd_sum[PROD_W-1:COEF_FRAC]});

  assign ramp_sum = {{2{cur_sel[COEF_W-1]}}, cur_sel}
                  + prod_q[RAMP_SHIFT+COEF_W+1:RAMP_SHIFT];

  always_comb begin
    if (ramp_sum[COEF_W+1:COEF_W-1] == 3'b000 || ramp_sum[COEF_W+1:COEF_W-1] == 3'b111) begin
      ramp_new = ramp_sum[COEF_W-1:0];
    end else if (ramp_sum[COEF_W+1]) begin
      ramp_new = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      ramp_new = {1'b0, {(COEF_W-1){1'b1}}};
    end
  end

  always_comb begin
    case (cmd_i.acc_op)
      ACC_LOAD_X: acc_d = $signed({{(ACC_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q});
      ACC_SUB:    acc_d = acc_q - rnd;
      ACC_ADD:    acc_d = acc_q + rnd;
      ACC_CLR:    acc_d = '0;
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      for (int i = 0; i < NUM_COEF; i++) begin
        tgt_q[i] <= '0;
      end
      tgt_q[COEF_B0] <= COEF_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE: enable_q       <= cfg_data_i[0];
        CFG_TGT_B0: tgt_q[COEF_B0] <= cfg_data_i;
        CFG_TGT_B1: tgt_q[COEF_B1] <= cfg_data_i;
        CFG_TGT_B2: tgt_q[COEF_B2] <= cfg_data_i;
        CFG_TGT_A1: tgt_q[COEF_A1] <= cfg_data_i;
        CFG_TGT_A2: tgt_q[COEF_A2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        cur_q[i] <= '0;
      end
      cur_q[COEF_B0] <= COEF_ONE;
    end else if (cmd_i.coef_wr) begin
      cur_q[cmd_i.coef_idx] <= ramp_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_q <= '0;
      d1_q <= '0;
    end else if (cmd_i.out_load && !cmd_i.out_pass) begin
      d1_q <= d0_q;
      d0_q <= w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.x_load) begin
      x_q <= in_sample_i;
    end
    if (cmd_i.w_load) begin
      w_q <= sat_state(acc_q);
    end
    if (cmd_i.diff_load) begin
      diff_q <= diff_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
    if (cmd_i.out_load) begin
      out_q <= cmd_i.out_pass ? x_q : sat_sample(acc_q);
    end
  end

  assign sts_o.enable = enable_q;
  assign out_sample_o = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/bqd_ctrl.sv @@
// Controller: sequences the shared multiplier and accumulator per item.
`default_nettype none

module bqd_ctrl import bqd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_valid_i,
  input  wire logic s_func_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  wire logic m_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SAMPLE = 2'd1;
  localparam logic [1:0] ST_RAMP   = 2'd2;
  localparam logic [1:0] ST_FIN    = 2'd3;

  localparam logic [2:0] SAMPLE_LAST = 3'd6;

  localparam logic [1:0] PH_DIFF = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_WR   = 2'd2;

  localparam logic [COEF_IDX_W-1:0] IDX_LAST = COEF_IDX_W'(NUM_COEF - 1);

  logic [1:0]            state_q, state_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [1:0]            phase_q, phase_d;
  logic [COEF_IDX_W-1:0] idx_q, idx_d;
  logic                  pass_q, pass_d;
  logic                  out_vld_q, out_vld_d;
  logic                  accept;
  logic                  out_free;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign out_free  = !out_vld_q || m_ready_i;
  assign m_valid_o = out_vld_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.x_load = accept;

    unique case (state_q)
      ST_IDLE: begin
        cnt_d   = '0;
        phase_d = PH_DIFF;
        idx_d   = '0;
        if (accept) begin
          if (s_func_i == FUNC_RAMP) begin
            state_d = ST_RAMP;
          end else if (sts_i.enable) begin
            pass_d  = 1'b0;
            state_d = ST_SAMPLE;
          end else begin
            pass_d  = 1'b1;
            state_d = ST_FIN;
          end
        end
      end

      ST_SAMPLE: begin
        cnt_d = cnt_q + 3'd1;
        unique case (cnt_q)
          3'd0: begin
            cmd_o.acc_op   = ACC_LOAD_X;
            cmd_o.mul_en   = 1'b1;
            cmd_o.coef_idx = COEF_A1;
            cmd_o.b_sel    = BSEL_D0;
          end
          3'd1: begin
            cmd_o.acc_op   = ACC_SUB;
            cmd_o.mul_en   = 1'b1;
            cmd_o.coef_idx = COEF_A2;
            cmd_o.b_sel    = BSEL_D1;
          end
          3'd2: begin
            cmd_o.acc_op = ACC_SUB;
          end
          3'd3: begin
            cmd_o.w_load   = 1'b1;
            cmd_o.acc_op   = ACC_CLR;
            cmd_o.mul_en   = 1'b1;
            cmd_o.coef_idx = COEF_B1;
            cmd_o.b_sel    = BSEL_D0;
          end
          3'd4: begin
            cmd_o.acc_op   = ACC_ADD;
            cmd_o.mul_en   = 1'b1;
            cmd_o.coef_idx = COEF_B2;
            cmd_o.b_sel    = BSEL_D1;
          end
          3'd5: begin
            cmd_o.acc_op   = ACC_ADD;
            cmd_o.mul_en   = 1'b1;
            cmd_o.coef_idx = COEF_B0;
            cmd_o.b_sel    = BSEL_W;
          end
          default: begin
            cmd_o.acc_op = ACC_ADD;
          end
        endcase
        if (cnt_q == SAMPLE_LAST) begin
          state_d = ST_FIN;
        end
      end

      ST_RAMP: begin
        cmd_o.coef_idx = idx_q;
        cmd_o.a_diff   = 1'b1;
        cmd_o.b_sel    = BSEL_RAMP;
        unique case (phase_q)
          PH_DIFF: begin
            cmd_o.diff_load = 1'b1;
            phase_d         = PH_MUL;
          end
          PH_MUL: begin
            cmd_o.mul_en = 1'b1;
            phase_d      = PH_WR;
          end
          default: begin
            cmd_o.coef_wr = 1'b1;
            phase_d       = PH_DIFF;
            idx_d         = idx_q + COEF_IDX_W'(1);
            if (idx_q == IDX_LAST) begin
              state_d = ST_IDLE;
            end
          end
        endcase
      end

      default: begin
        cmd_o.out_pass = pass_q;
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase
  end

  assign out_vld_d = (out_vld_q && !m_ready_i) || cmd_o.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      phase_q   <= PH_DIFF;
      idx_q     <= '0;
      pass_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      pass_q    <= pass_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/biquad_df2_with_coef_smoothing_unit.sv @@
// Filtered sample: runs the sample sequence on the shared multiplier, then loads the output.
// Bypass sample: the input sample is passed straight to the output. Ramp word: no output word.
// One shared 33x32 multiplier serves five products in turn; words are accepted only in idle.
// A word waiting at the output stalls only the final write of the next result.
// Reset: delay line zero, working and target coefficients pass-through (b0 = 1.0),
// filter enabled, no output word pending.
`default_nettype none

module biquad_df2_with_coef_smoothing_unit import bqd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]  s_axis_tdata,   // [23:0] in_sample
  input  wire logic                 s_axis_tuser,   // [0] func
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [SAMPLE_W-1:0]  m_axis_tdata,   // [23:0] out_sample
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [COEF_W-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  bqd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_func_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bqd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (s_axis_tdata),
    .out_sample_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ tb/biquad_df2_with_coef_smoothing_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench: biquad sample filtering, bypass and coefficient ramps.
module biquad_df2_with_coef_smoothing_unit_tb;
  import bqd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam int unsigned RAMP_SETTLE = 20;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned STUCK_LIMIT = 2000;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SAMPLE_W-1:0]  s_axis_tdata  = '0;
  logic                 s_axis_tuser  = FUNC_SAMPLE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]  m_axis_tdata;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = CFG_ENABLE;
  logic [COEF_W-1:0]    cfg_data_i    = '0;

  logic                      filt_en;
  logic signed [COEF_W-1:0]  coef_target [NUM_COEF];
  logic signed [COEF_W-1:0]  coef_work [NUM_COEF];
  logic signed [STATE_W-1:0] delay_w [2];
  logic [SAMPLE_W-1:0]       pending_out_samples [$];
  logic [SAMPLE_W-1:0]       want_sample;

  int errors         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int stuck_cycles   = 0;

  biquad_df2_with_coef_smoothing_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clip(input longint v, input int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    if (v > hi) return hi;
    if (v < -hi - 64'sd1) return -hi - 64'sd1;
    return v;
  endfunction

  function automatic longint round_mul(input longint c, input longint v);
    return (c * v + 64'sh800_0000) >>> COEF_FRAC;
  endfunction

  function automatic void filter_reset_state();
    filt_en = 1'b1;
    for (int i = 0; i < NUM_COEF; i++) begin
      coef_target[i] = '0;
      coef_work[i]   = '0;
    end
    coef_target[COEF_B0] = COEF_ONE;
    coef_work[COEF_B0]   = COEF_ONE;
    delay_w[0] = '0;
    delay_w[1] = '0;
  endfunction

  function automatic void biquad_step(input logic func, input logic [SAMPLE_W-1:0] smp);
    longint x, w, y, d0, d1, gap;
    if (func == FUNC_RAMP) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        gap = longint'(coef_target[i]) - longint'(coef_work[i]);
        coef_work[i] = COEF_W'(clip(longint'(coef_work[i])
                       + ((gap * longint'(RAMP_NUM)) >>> RAMP_SHIFT), COEF_W));
      end
      return;
    end
    x = longint'($signed(smp));
    if (filt_en) begin
      d0 = delay_w[0];
      d1 = delay_w[1];
      w = clip(x - round_mul(coef_work[COEF_A1], d0)
               - round_mul(coef_work[COEF_A2], d1), STATE_W);
      y = clip(round_mul(coef_work[COEF_B0], w) + round_mul(coef_work[COEF_B1], d0)
               + round_mul(coef_work[COEF_B2], d1), SAMPLE_W);
      delay_w[1] = delay_w[0];
      delay_w[0] = STATE_W'(w);
    end else begin
      y = x;
    end
    pending_out_samples.push_back(SAMPLE_W'(y));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ENABLE: filt_en = cfg_data_i[0];
        CFG_TGT_B0: coef_target[COEF_B0] = cfg_data_i;
        CFG_TGT_B1: coef_target[COEF_B1] = cfg_data_i;
        CFG_TGT_B2: coef_target[COEF_B2] = cfg_data_i;
        CFG_TGT_A1: coef_target[COEF_A1] = cfg_data_i;
        CFG_TGT_A2: coef_target[COEF_A2] = cfg_data_i;
        default: ;
      endcase
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      biquad_step(s_axis_tuser, s_axis_tdata);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out_samples.size() == 0) begin
        $display("%0t: out_sample expected none actual %06h", $time, m_axis_tdata);
        errors++;
      end else begin
        want_sample = pending_out_samples.pop_front();
        if (m_axis_tdata !== want_sample) begin
          $display("%0t: out_sample expected %06h actual %06h",
                   $time, want_sample, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
      $display("biquad_df2_with_coef_smoothing_unit_tb failed");
      $finish;
    end
  end

  task automatic send_word(input logic func, input logic [SAMPLE_W-1:0] smp);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_out_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    idle_sender();
    repeat (RAMP_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [SAMPLE_W-1:0] v;
    v = SAMPLE_W'($urandom);
    if ($urandom_range(2) != 0) v = {{7{v[16]}}, v[16:0]};
    return v;
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(input int unsigned span);
    return COEF_W'($urandom_range(2 * span)) - COEF_W'(span);
  endfunction

  task automatic load_random_filter();
    settle();
    write_reg(CFG_ENABLE, COEF_W'($urandom_range(7) != 0));
    if ($urandom_range(4) == 0) begin
      write_reg(CFG_TGT_B0, $urandom);
      write_reg(CFG_TGT_B1, $urandom);
      write_reg(CFG_TGT_B2, $urandom);
      write_reg(CFG_TGT_A1, $urandom);
      write_reg(CFG_TGT_A2, $urandom);
    end else begin
      write_reg(CFG_TGT_B0, rand_coef(32'd1 << 29));
      write_reg(CFG_TGT_B1, rand_coef(32'd1 << 29));
      write_reg(CFG_TGT_B2, rand_coef(32'd1 << 29));
      write_reg(CFG_TGT_A1, rand_coef(32'd510000000));
      write_reg(CFG_TGT_A2, rand_coef(32'd240000000));
    end
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
    end
  endtask

  task automatic test_passthrough_reset();
    send_word(FUNC_SAMPLE, 24'h000000);
    send_word(FUNC_SAMPLE, 24'h7FFFFF);
    send_word(FUNC_SAMPLE, 24'h800000);
    send_word(FUNC_SAMPLE, 24'hFFFFFF);
    send_word(FUNC_SAMPLE, 24'h000001);
    send_word(FUNC_SAMPLE, 24'h555555);
    send_word(FUNC_SAMPLE, 24'hAAAAAA);
  endtask

  task automatic test_bypass_disabled();
    settle();
    write_reg(CFG_ENABLE, '0);
    write_reg(CFG_TGT_B1, 32'h7FFF_FFFF);
    send_word(FUNC_RAMP, 24'hFFFFFF);
    send_word(FUNC_SAMPLE, 24'h7FFFFF);
    send_word(FUNC_RAMP, 24'h000000);
    send_word(FUNC_SAMPLE, 24'h800000);
    send_word(FUNC_SAMPLE, 24'h123456);
  endtask

  task automatic test_coef_extremes();
    settle();
    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_TGT_B0, 32'h7FFF_FFFF);
    write_reg(CFG_TGT_B2, 32'h8000_0000);
    write_reg(CFG_TGT_A1, 32'h8000_0000);
    write_reg(CFG_TGT_A2, 32'h7FFF_FFFF);
    repeat (4) send_word(FUNC_RAMP, 24'h5A5A5A);
    send_word(FUNC_SAMPLE, 24'h7FFFFF);
    send_word(FUNC_SAMPLE, 24'h800000);
    send_word(FUNC_SAMPLE, 24'h7FFFFF);
    send_word(FUNC_SAMPLE, 24'h000000);
    send_word(FUNC_SAMPLE, 24'h800000);
  endtask

  task automatic test_spare_index();
    settle();
    write_reg(CFG_SPARE_6, '0);
    write_reg(CFG_SPARE_7, '0);
    send_word(FUNC_SAMPLE, 24'h400000);
    send_word(FUNC_RAMP, 24'h000000);
    send_word(FUNC_SAMPLE, 24'hC00000);
  endtask

  task automatic test_ramp_near_target();
    settle();
    write_reg(CFG_TGT_B0, coef_work[COEF_B0] + 32'sd15);
    write_reg(CFG_TGT_B1, coef_work[COEF_B1] + 32'sd19);
    write_reg(CFG_TGT_B2, coef_work[COEF_B2] + 32'sd1);
    write_reg(CFG_TGT_A1, coef_work[COEF_A1] + 32'sd10);
    write_reg(CFG_TGT_A2, coef_work[COEF_A2] + 32'sd19);
    send_word(FUNC_RAMP, 24'h000000);
    send_word(FUNC_RAMP, 24'hFFFFFF);
    send_word(FUNC_SAMPLE, 24'h0F0F0F);
  endtask

  task automatic test_random_traffic(input int sidle, input int rstall, input int n_items);
    int left;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    for (int seg = 0; seg < 2; seg++) begin
      load_random_filter();
      left = n_items / 2;
      while (left > 0) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(8, 1)) begin
            send_word(FUNC_RAMP, SAMPLE_W'($urandom));
            left--;
          end
        end else begin
          send_word(FUNC_SAMPLE, rand_sample());
          left--;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_random_filter();
    hold_req++;
    repeat (40) send_word(FUNC_SAMPLE, rand_sample());
    idle_sender();
    repeat (40) begin
      send_word(($urandom_range(5) == 0) ? FUNC_RAMP : FUNC_SAMPLE, rand_sample());
    end
  endtask

  initial begin
    filter_reset_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough_reset();
    test_bypass_disabled();
    test_coef_extremes();
    test_spare_index();
    test_ramp_near_target();
    test_random_traffic(0, 0, 260);
    test_random_traffic(48, 0, 260);
    test_random_traffic(0, 48, 260);
    test_random_traffic(35, 35, 260);
    test_backpressure();
    idle_sender();
    repeat (RAMP_SETTLE) @(posedge clk_i);
    if (pending_out_samples.size() != 0) begin
      $display("%0t: %0d out_sample words never arrived", $time, pending_out_samples.size());
      errors++;
    end
    if (errors == 0) begin
      $display("biquad_df2_with_coef_smoothing_unit_tb passed");
    end else begin
      $display("biquad_df2_with_coef_smoothing_unit_tb failed");
    end
    $finish;
  end

endmodule
